// ----- hdl/ltc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Types and codes shared by the tile cache: operation codes, key and stamp
// widths, sequencer states and the memory write control bundle.
// ----------------------------------------------------------------------------
package ltc_pkg;

	localparam int KEY_BITS   = 47;
	localparam int STAMP_BITS = 64;
	localparam int CAP_BITS   = 7;
	localparam int X_BITS     = 21;
	localparam int Y_BITS     = 21;
	localparam int LVL_BITS   = 5;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic key_en;
		logic pay_en;
		logic stamp_en;
	} mem_wr_t;

endpackage

// ----- hdl/lru_tile_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tile_cache
// Fully associative least-recently-used cache of tile payload handles keyed
// by (tile_x, tile_y, tile_level), with lookup, insert and clear.
// ----------------------------------------------------------------------------
// Usage:
// - input channel: in_valid / in_stall carries op, tile_x, tile_y, tile_level
//   and payload_in; a transaction happens when in_valid is high and in_stall
//   is low. in_stall stays high while an operation is in progress.
// - output channel: out_valid / out_stall carries hit and payload_out, one
//   result per input transaction, held in an output register.
// - config channel: cfg_valid / cfg_ready writes capacity (cfg_ready is
//   always high); write only while the cache is idle.
// - lookup and insert scan every entry through a single read port of the
//   key, payload and stamp memories, one entry per cycle, with one key
//   comparator and one stamp comparator, then pass through the drain,
//   decide and done states before the result loads into the output
//   register. Clear and the unused op go straight to the done state.
// - reset clears all valid bits, the occupancy, the use counter and sets
//   capacity to ENTRIES; no clearing pass is needed.
// - while the output register holds a result and out_stall is high, a
//   finished result waits and no new input is taken until the register frees.
// ----------------------------------------------------------------------------
module lru_tile_cache #(
	parameter int ENTRIES      = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic [ltc_pkg::X_BITS-1:0]        tile_x,
	input  logic [ltc_pkg::Y_BITS-1:0]        tile_y,
	input  logic [ltc_pkg::LVL_BITS-1:0]      tile_level,
	input  logic [PAYLOAD_BITS-1:0]           payload_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [PAYLOAD_BITS-1:0]           payload_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ltc_pkg::CAP_BITS-1:0]      cfg_data
);
	import ltc_pkg::*;

	localparam int AW      = $clog2(ENTRIES);
	localparam int OW      = $clog2(ENTRIES + 1);
	localparam int CW      = (OW > CAP_BITS) ? OW : CAP_BITS;

	st_t state_q, state_d;

	logic [KEY_BITS-1:0]     key_mem   [ENTRIES];
	logic [PAYLOAD_BITS-1:0] pay_mem   [ENTRIES];
	logic [STAMP_BITS-1:0]   stamp_mem [ENTRIES];
	logic [KEY_BITS-1:0]     key_rd_q;
	logic [PAYLOAD_BITS-1:0] pay_rd_q;
	logic [STAMP_BITS-1:0]   stamp_rd_q;

	logic [ENTRIES-1:0]      valid_q;
	logic [OW-1:0]           occ_q;
	logic [STAMP_BITS-1:0]   ctr_q;
	logic [CW-1:0]           cap_q;

	logic [1:0]              op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [AW-1:0]           idx_q;

	logic                    busy_s1;
	logic                    vbit_s1;
	logic [AW-1:0]           idx_s1;

	logic                    match_found_q;
	logic [AW-1:0]           match_idx_q;
	logic [PAYLOAD_BITS-1:0] match_pay_q;
	logic                    vict_found_q;
	logic [AW-1:0]           vict_idx_q;
	logic [STAMP_BITS-1:0]   vict_stamp_q;
	logic                    free_found_q;
	logic [AW-1:0]           free_idx_q;

	logic                    res_hit_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic                    out_valid_q;
	logic                    hit_q;
	logic [PAYLOAD_BITS-1:0] payload_out_q;

	logic                    in_take;
	logic                    out_load;
	logic                    scan_last;
	logic [CW-1:0]           cap_eff;
	logic                    do_evict;
	logic [AW-1:0]           ins_slot;
	logic [AW-1:0]           wr_addr;
	mem_wr_t                 wr;

	assign in_take   = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign scan_last = (idx_q == AW'(ENTRIES - 1));
	assign cfg_ready = 1'b1;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_q > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign do_evict = (CW'(occ_q) >= cap_eff);

	always_comb begin
		if (match_found_q) begin
			ins_slot = match_idx_q;
		end else if (do_evict && !(free_found_q && (free_idx_q < vict_idx_q))) begin
			ins_slot = vict_idx_q;
		end else begin
			ins_slot = free_idx_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (op == OP_LOOKUP || op == OP_INSERT) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		wr       = '0;
		wr_addr  = ins_slot;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_DECIDE: begin
				if (op_q == OP_LOOKUP) begin
					wr.stamp_en = match_found_q;
					wr_addr     = match_idx_q;
				end else begin
					wr.key_en   = !match_found_q;
					wr.pay_en   = 1'b1;
					wr.stamp_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.key_en) begin
			key_mem[wr_addr] <= key_q;
		end
		if (wr.pay_en) begin
			pay_mem[wr_addr] <= pay_q;
		end
		if (wr.stamp_en) begin
			stamp_mem[wr_addr] <= ctr_q;
		end
		key_rd_q   <= key_mem[idx_q];
		pay_rd_q   <= pay_mem[idx_q];
		stamp_rd_q <= stamp_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		vbit_s1 <= valid_q[idx_q];
		if (in_take) begin
			op_q  <= op;
			key_q <= {tile_level, tile_y, tile_x};
			pay_q <= payload_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			occ_q         <= '0;
			ctr_q         <= '0;
			cap_q         <= CW'(ENTRIES);
			idx_q         <= '0;
			busy_s1       <= 1'b0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			match_pay_q   <= '0;
			vict_found_q  <= 1'b0;
			vict_idx_q    <= '0;
			vict_stamp_q  <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			res_hit_q     <= 1'b0;
			res_pay_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= CW'(cfg_data);
			end
			busy_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + AW'(1);
			end
			if (in_take) begin
				idx_q         <= '0;
				match_found_q <= 1'b0;
				vict_found_q  <= 1'b0;
				free_found_q  <= 1'b0;
				res_hit_q     <= 1'b0;
				res_pay_q     <= '0;
				if (op == OP_CLEAR) begin
					valid_q <= '0;
					occ_q   <= '0;
					ctr_q   <= '0;
				end
			end
			// shared compare on the entry read last cycle
			if (busy_s1) begin
				if (vbit_s1 && !match_found_q && (key_rd_q == key_q)) begin
					match_found_q <= 1'b1;
					match_idx_q   <= idx_s1;
					match_pay_q   <= pay_rd_q;
				end
				if (vbit_s1 && (!vict_found_q || (stamp_rd_q < vict_stamp_q))) begin
					vict_found_q <= 1'b1;
					vict_idx_q   <= idx_s1;
					vict_stamp_q <= stamp_rd_q;
				end
				if (!vbit_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end
			if (state_q == ST_DECIDE) begin
				if (op_q == OP_LOOKUP) begin
					if (match_found_q) begin
						ctr_q     <= ctr_q + STAMP_BITS'(1);
						res_hit_q <= 1'b1;
						res_pay_q <= match_pay_q;
					end
				end else begin
					ctr_q <= ctr_q + STAMP_BITS'(1);
					if (!match_found_q) begin
						if (do_evict) begin
							valid_q[vict_idx_q] <= 1'b0;
						end else begin
							occ_q <= occ_q + OW'(1);
						end
						valid_q[ins_slot] <= 1'b1;
					end
				end
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q         <= res_hit_q;
			payload_out_q <= res_pay_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign payload_out = payload_out_q;

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (int'(occ_q) == $countones(valid_q)))
		else $error("occupancy does not match valid bits");

	a_stall_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input taken while an operation is in progress");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result presented outside the done state");

	a_slot_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && op_q == OP_INSERT && !match_found_q)
		|-> (do_evict ? vict_found_q : free_found_q))
		else $error("insert without a victim or free entry");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_tile_cache. A short directed table covers the
// field extremes, every op, in-place update, eviction order and capacity
// values outside the legal range. Random phases follow. Each phase works on a
// pool of keys that exceeds the effective capacity by one to six, so hits,
// misses and evictions all occur. Idle and stall rates vary by phase.
// A shadow cache copy predicts every result not fixed by a directed row.
// ----------------------------------------------------------------------------
module testbench;

	import ltc_pkg::*;

	localparam int ENTRIES      = 64;
	localparam int PAYLOAD_BITS = 32;
	localparam int DRAIN_LIMIT  = 200000;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [X_BITS-1:0]   XY_MAX  = '1;
	localparam logic [LVL_BITS-1:0] LVL_MAX = '1;

	typedef enum logic {
		ROW_ITEM,
		ROW_CAP
	} row_kind_t;

	typedef struct packed {
		logic                    hit;
		logic [PAYLOAD_BITS-1:0] pay;
	} tile_result_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [1:0]              op;
		logic [X_BITS-1:0]       x;
		logic [Y_BITS-1:0]       y;
		logic [LVL_BITS-1:0]     lvl;
		logic [PAYLOAD_BITS-1:0] pay;
		logic [CAP_BITS-1:0]     cap;
		logic                    typed;
		tile_result_t            res;
	} stim_row_t;

	localparam tile_result_t NO_HIT = '{1'b0, 32'h0};

	localparam int DIR_N = 26;
	localparam stim_row_t DIRECTED [DIR_N] = '{
		'{ROW_ITEM, OP_LOOKUP, 21'd0, 21'd0, 5'd0, 32'h0, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_INSERT, 21'd0, 21'd0, 5'd0, 32'h0, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_INSERT, XY_MAX, XY_MAX, LVL_MAX, 32'hFFFF_FFFF, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, 21'd0, 21'd0, 5'd0, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, XY_MAX, XY_MAX, LVL_MAX, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_INSERT, 21'd0, 21'd0, 5'd0, 32'hA5A5_A5A5, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, 21'd0, 21'd0, 5'd0, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_UNUSED, XY_MAX, XY_MAX, LVL_MAX, 32'hFFFF_FFFF, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, XY_MAX, XY_MAX, LVL_MAX, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_CLEAR, 21'd0, 21'd0, 5'd0, 32'h0, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, XY_MAX, XY_MAX, LVL_MAX, 32'h0, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_INSERT, 21'd0, XY_MAX, 5'd0, 32'h5A5A_5A5A, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_INSERT, XY_MAX, 21'd0, LVL_MAX, 32'h1234_5678, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, 21'd0, XY_MAX, 5'd0, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, XY_MAX, 21'd0, LVL_MAX, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_CLEAR, 21'd0, 21'd0, 5'd0, 32'h0, 7'd0, 1'b1, NO_HIT},
		'{ROW_CAP, OP_LOOKUP, 21'd0, 21'd0, 5'd0, 32'h0, 7'd2, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_INSERT, 21'd1, 21'd1, 5'd1, 32'h0000_0011, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_INSERT, 21'd2, 21'd2, 5'd2, 32'h0000_0022, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, 21'd1, 21'd1, 5'd1, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_INSERT, 21'd3, 21'd3, 5'd3, 32'h0000_0033, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, 21'd2, 21'd2, 5'd2, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_CAP, OP_LOOKUP, 21'd0, 21'd0, 5'd0, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_ITEM, OP_INSERT, 21'd4, 21'd4, 5'd4, 32'h0000_0044, 7'd0, 1'b1, NO_HIT},
		'{ROW_ITEM, OP_LOOKUP, 21'd1, 21'd1, 5'd1, 32'h0, 7'd0, 1'b0, NO_HIT},
		'{ROW_CAP, OP_LOOKUP, 21'd0, 21'd0, 5'd0, 32'h0, 7'd127, 1'b0, NO_HIT}
	};

	// capacity, sender idle percent, receiver stall percent, items
	localparam int PH_N = 9;
	localparam int PHASE_CAP   [PH_N] = '{64, 1, 8, 127, 3, 0, 16, 64, 5};
	localparam int PHASE_IDLE  [PH_N] = '{0, 83, 0, 38, 0, 38, 83, 0, 38};
	localparam int PHASE_STALL [PH_N] = '{0, 0, 83, 38, 0, 38, 0, 83, 38};
	localparam int PHASE_ITEMS [PH_N] = '{200, 150, 200, 250, 150, 100, 200, 200, 150};

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic                    in_stall;
	logic [1:0]              op         = OP_LOOKUP;
	logic [X_BITS-1:0]       tile_x     = '0;
	logic [Y_BITS-1:0]       tile_y     = '0;
	logic [LVL_BITS-1:0]     tile_level = '0;
	logic [PAYLOAD_BITS-1:0] payload_in = '0;
	logic                    out_valid;
	logic                    out_stall  = 1'b0;
	logic                    hit;
	logic [PAYLOAD_BITS-1:0] payload_out;
	logic                    cfg_valid  = 1'b0;
	logic                    cfg_ready;
	logic [CAP_BITS-1:0]     cfg_data   = '0;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int fault_count    = 0;

	tile_result_t tile_results_due [$];

	// shadow copy of the cache contents
	logic                    shadow_valid   [ENTRIES];
	logic [KEY_BITS-1:0]     shadow_key     [ENTRIES];
	logic [PAYLOAD_BITS-1:0] shadow_payload [ENTRIES];
	logic [STAMP_BITS-1:0]   shadow_stamp   [ENTRIES];
	int                      shadow_occupancy = 0;
	logic [STAMP_BITS-1:0]   shadow_counter   = '0;
	int                      shadow_capacity  = ENTRIES;

	logic [KEY_BITS-1:0] key_pool [$];

	lru_tile_cache #(
		.ENTRIES     (ENTRIES),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.tile_level (tile_level),
		.payload_in (payload_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.payload_out(payload_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic tile_result_t predict_tile_access(logic [1:0] opc,
			logic [KEY_BITS-1:0] key, logic [PAYLOAD_BITS-1:0] pay);
		tile_result_t res;
		int slot;
		int victim;
		int eff;
		res  = '0;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && shadow_valid[i] && shadow_key[i] == key)
				slot = i;
		case (opc)
			OP_LOOKUP: begin
				if (slot >= 0) begin
					shadow_stamp[slot] = shadow_counter;
					shadow_counter++;
					res.hit = 1'b1;
					res.pay = shadow_payload[slot];
				end
			end
			OP_INSERT: begin
				if (slot < 0) begin
					eff = (shadow_capacity == 0) ? 1 :
						(shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
					if (shadow_occupancy >= eff) begin
						victim = -1;
						for (int i = 0; i < ENTRIES; i++)
							if (shadow_valid[i] &&
									(victim < 0 || shadow_stamp[i] < shadow_stamp[victim]))
								victim = i;
						if (victim >= 0) begin
							shadow_valid[victim] = 1'b0;
							shadow_occupancy--;
						end
					end
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !shadow_valid[i])
							slot = i;
					if (slot >= 0) begin
						shadow_valid[slot] = 1'b1;
						shadow_key[slot]   = key;
						shadow_occupancy++;
					end
				end
				if (slot >= 0) begin
					shadow_payload[slot] = pay;
					shadow_stamp[slot]   = shadow_counter;
					shadow_counter++;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					shadow_valid[i] = 1'b0;
				shadow_occupancy = 0;
				shadow_counter   = '0;
			end
			default: ;
		endcase
		return res;
	endfunction

	// present one request and hold it until the transaction happens
	task automatic drive_item(logic [1:0] opc, logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y,
			logic [LVL_BITS-1:0] lvl, logic [PAYLOAD_BITS-1:0] pay,
			logic typed, tile_result_t typed_res);
		tile_result_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= opc;
		tile_x     <= x;
		tile_y     <= y;
		tile_level <= lvl;
		payload_in <= pay;
		do @(posedge clk); while (in_stall);
		res = predict_tile_access(opc, {lvl, y, x}, pay);
		tile_results_due = {tile_results_due, (typed ? typed_res : res)};
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (tile_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (ENTRIES + 8) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_capacity = value;
	endtask

	task automatic run_phase(int cap, int idle_pct, int stall_pct, int count);
		int eff;
		int pool_n;
		int r;
		logic [KEY_BITS-1:0] key;
		logic [1:0] opc;
		drain_results();
		set_capacity(cap[CAP_BITS-1:0]);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		eff = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
		pool_n = eff + $urandom_range(1, 6);
		key_pool.delete();
		for (int i = 0; i < pool_n; i++) begin
			// near neighbors differ from an earlier key in a single bit
			if (i > 0 && $urandom_range(1))
				key = key_pool[$urandom_range(i - 1)] ^ (47'd1 << $urandom_range(KEY_BITS - 1));
			else
				key = KEY_BITS'({$urandom, $urandom});
			key_pool = {key_pool, key};
		end
		for (int n = 0; n < count; n++) begin
			r   = $urandom_range(99);
			key = key_pool[$urandom_range(pool_n - 1)];
			if (r < 45)
				opc = OP_LOOKUP;
			else if (r < 88)
				opc = OP_INSERT;
			else if (r < 95) begin
				opc = (r < 92) ? OP_LOOKUP : OP_INSERT;
				key = KEY_BITS'({$urandom, $urandom});
			end else if (r < 97)
				opc = OP_CLEAR;
			else begin
				opc = OP_UNUSED;
				key = KEY_BITS'({$urandom, $urandom});
			end
			drive_item(opc, key[20:0], key[41:21], key[46:42], $urandom, 1'b0, NO_HIT);
		end
	endtask

	// receiver: random stall and result check
	always @(posedge clk) begin
		tile_result_t due;
		out_stall <= ($urandom_range(99) < sink_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (tile_results_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t unexpected result: hit %0b payload %h", $realtime, hit,
						payload_out);
			end else begin
				due = tile_results_due.pop_front();
				if (hit !== due.hit || payload_out !== due.pay) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t mismatch: expected hit %0b payload %h, got hit %0b payload %h",
							$realtime, due.hit, due.pay, hit, payload_out);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++)
			shadow_valid[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (DIRECTED[i].kind == ROW_CAP) begin
				drain_results();
				set_capacity(DIRECTED[i].cap);
			end else
				drive_item(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].lvl,
					DIRECTED[i].pay, DIRECTED[i].typed, DIRECTED[i].res);
		end

		for (int p = 0; p < PH_N; p++)
			run_phase(PHASE_CAP[p], PHASE_IDLE[p], PHASE_STALL[p], PHASE_ITEMS[p]);

		drain_results();
		if (tile_results_due.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
